// ===== rtl/core/bba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants, types and helpers for the first-fit block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int BLOCK_BASE        = 1024;
    localparam int MAP_BYTES         = 7168;
    localparam int RESERVED_LOW_LAST = 9;

    localparam int OP_W   = 2;
    localparam int BLK_W  = 16;
    localparam int OFF_W  = 17;
    localparam int WORD_W = 64;
    localparam int SEL_W  = 6;

    localparam int MAP_BITS   = MAP_BYTES * 8;
    localparam int NUM_WORDS  = (MAP_BYTES + 7) / 8;
    localparam int NUM_GROUPS = (NUM_WORDS + WORD_W - 1) / WORD_W;
    localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int ADDR_W     = GRP_W + SEL_W;
    localparam int MEM_DEPTH  = NUM_GROUPS * WORD_W;
    localparam int LAST_VALID = MAP_BITS - WORD_W * (NUM_WORDS - 1);

    typedef enum logic [OP_W-1:0] {
        OP_PEEK  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_TEST  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADDR,
        S_READ,
        S_MOD
    } t_state;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic              full;
    } t_sum_upd;

    // Return {hit, index} of the lowest clear bit of a word.
    function automatic logic [SEL_W:0] first_zero(input logic [WORD_W-1:0] w);
        logic [SEL_W:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!w[i]) begin
                r = {1'b1, SEL_W'(i)};
            end
        end
        return r;
    endfunction

    // Bits past the end of the map in the last word read as used.
    function automatic logic [WORD_W-1:0] last_pad();
        logic [WORD_W-1:0] r;
        r = '0;
        for (int i = 0; i < WORD_W; i++) begin
            r[i] = (i >= LAST_VALID);
        end
        return r;
    endfunction

    // Summary bits of words past the end of the map start out full.
    function automatic logic [WORD_W-1:0] summary_init(input int g);
        logic [WORD_W-1:0] r;
        r = '0;
        for (int i = 0; i < WORD_W; i++) begin
            r[i] = ((g * WORD_W + i) >= NUM_WORDS);
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/block_bitmap_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_bitmap_allocator
// First-fit block allocator over a used-bit map: peek, allocate, free, test.
// ----------------------------------------------------------------------------
// Steps from input beat to result beat: accept, summary search, map read,
// modify and write back. One request is in flight: the input stalls until
// the request leaves the write-back step. Result sits in an output register;
// a stalled result holds the block in the write-back step. After reset the
// map is cleared one 64-bit word a cycle, all MEM_DEPTH words (896 at the
// default size), with the input stalled.
module block_bitmap_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [bba_pkg::OP_W-1:0]    i_opcode,
    input  logic [bba_pkg::BLK_W-1:0]   i_block_number,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [bba_pkg::BLK_W-1:0]   o_result_block,
    output logic                        o_found,
    output logic                        o_is_used
);

    localparam logic [bba_pkg::WORD_W-1:0] LAST_PAD = bba_pkg::last_pad();
    localparam logic [bba_pkg::WORD_W-1:0] WORD_W_ONE = {{(bba_pkg::WORD_W-1){1'b0}}, 1'b1};

    bba_pkg::t_state r_state, n_state;

    logic [bba_pkg::ADDR_W-1:0] r_clr, n_clr;
    bba_pkg::t_op               r_op, n_op;
    logic [bba_pkg::BLK_W-1:0]  r_blk, n_blk;
    logic [bba_pkg::ADDR_W-1:0] r_addr, n_addr;
    logic [bba_pkg::SEL_W-1:0]  r_bit, n_bit;
    logic                       r_hit, n_hit;

    logic                       r_out_valid, n_out_valid;
    logic [bba_pkg::BLK_W-1:0]  r_result_block, n_result_block;
    logic                       r_found, n_found;
    logic                       r_is_used, n_is_used;

    logic                       w_any_free;
    logic [bba_pkg::ADDR_W-1:0] w_free_addr;
    bba_pkg::t_sum_upd          w_upd;

    logic                       w_we;
    logic [bba_pkg::ADDR_W-1:0] w_waddr;
    logic [bba_pkg::WORD_W-1:0] w_wdata;
    logic [bba_pkg::WORD_W-1:0] w_rdata;
    logic [bba_pkg::WORD_W-1:0] w_clr_word;

    logic [bba_pkg::OFF_W-1:0]  w_off;
    logic                       w_in_range;
    logic [bba_pkg::SEL_W:0]    w_zero;
    logic [bba_pkg::WORD_W-1:0] w_mask;
    logic [31:0]                w_sum;

    bba_search u_search (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_upd       (w_upd),
        .o_any_free  (w_any_free),
        .o_free_addr (w_free_addr)
    );

    bba_map_ram u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    assign w_off = bba_pkg::OFF_W'(r_blk) - bba_pkg::OFF_W'(bba_pkg::BLOCK_BASE);
    assign w_in_range = (32'(r_blk) >= 32'(bba_pkg::BLOCK_BASE))
                     && (32'(w_off) < 32'(bba_pkg::MAP_BITS));

    assign w_zero = bba_pkg::first_zero(w_rdata);
    assign w_sum  = 32'(bba_pkg::BLOCK_BASE) + 32'({r_addr, w_zero[bba_pkg::SEL_W-1:0]});

    always_comb begin
        if (32'(r_clr) == 32'(bba_pkg::NUM_WORDS - 1)) begin
            w_clr_word = LAST_PAD;
        end else if (32'(r_clr) > 32'(bba_pkg::NUM_WORDS - 1)) begin
            w_clr_word = '1;
        end else begin
            w_clr_word = '0;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_clr          = r_clr;
        n_op           = r_op;
        n_blk          = r_blk;
        n_addr         = r_addr;
        n_bit          = r_bit;
        n_hit          = r_hit;
        n_out_valid    = r_out_valid && i_out_stall;
        n_result_block = r_result_block;
        n_found        = r_found;
        n_is_used      = r_is_used;
        w_we           = 1'b0;
        w_waddr        = r_addr;
        w_wdata        = w_rdata;
        w_mask         = '0;
        w_upd          = '0;

        case (r_state)
            bba_pkg::S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = w_clr_word;
                n_clr   = r_clr + bba_pkg::ADDR_W'(1);
                if (32'(r_clr) == 32'(bba_pkg::MEM_DEPTH - 1)) begin
                    n_state = bba_pkg::S_IDLE;
                end
            end
            bba_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = bba_pkg::t_op'(i_opcode);
                    n_blk   = i_block_number;
                    n_state = bba_pkg::S_ADDR;
                end
            end
            bba_pkg::S_ADDR: begin
                if (r_op == bba_pkg::OP_PEEK || r_op == bba_pkg::OP_ALLOC) begin
                    n_addr = w_free_addr;
                    n_hit  = w_any_free;
                end else begin
                    n_addr = w_off[bba_pkg::ADDR_W+bba_pkg::SEL_W-1:bba_pkg::SEL_W];
                    n_bit  = w_off[bba_pkg::SEL_W-1:0];
                    n_hit  = w_in_range;
                end
                n_state = bba_pkg::S_READ;
            end
            bba_pkg::S_READ: begin
                n_state = bba_pkg::S_MOD;
            end
            bba_pkg::S_MOD: begin
                // Finish only when the output register is free this cycle.
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid    = 1'b1;
                    n_result_block = '0;
                    n_found        = 1'b0;
                    n_is_used      = 1'b0;
                    case (r_op)
                        bba_pkg::OP_PEEK, bba_pkg::OP_ALLOC: begin
                            w_mask = WORD_W_ONE << w_zero[bba_pkg::SEL_W-1:0];
                            w_wdata = w_rdata | w_mask;
                            w_we    = r_hit && (r_op == bba_pkg::OP_ALLOC);
                            if (r_hit) begin
                                n_result_block = w_sum[bba_pkg::BLK_W-1:0];
                                n_found        = 1'b1;
                            end
                        end
                        bba_pkg::OP_FREE: begin
                            w_mask  = WORD_W_ONE << r_bit;
                            w_wdata = w_rdata & ~w_mask;
                            w_we    = r_hit;
                        end
                        bba_pkg::OP_TEST: begin
                            n_is_used = r_hit
                                && (32'(r_blk) > 32'(bba_pkg::RESERVED_LOW_LAST))
                                && w_rdata[r_bit];
                        end
                        default: begin
                            w_we = 1'b0;
                        end
                    endcase
                    w_upd.en   = w_we;
                    w_upd.addr = r_addr;
                    w_upd.full = &w_wdata;
                    n_state    = bba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bba_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bba_pkg::S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op           <= n_op;
        r_blk          <= n_blk;
        r_addr         <= n_addr;
        r_bit          <= n_bit;
        r_hit          <= n_hit;
        r_result_block <= n_result_block;
        r_found        <= n_found;
        r_is_used      <= n_is_used;
    end

    assign o_in_stall     = (r_state != bba_pkg::S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_result_block = r_result_block;
    assign o_found        = r_found;
    assign o_is_used      = r_is_used;

endmodule

// ===== rtl/core/bba_map_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_map_ram
// Used-bit map storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bba_map_ram (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [bba_pkg::ADDR_W-1:0]        i_waddr,
    input  logic [bba_pkg::WORD_W-1:0]        i_wdata,
    input  logic [bba_pkg::ADDR_W-1:0]        i_raddr,
    output logic [bba_pkg::WORD_W-1:0]        o_rdata
);

    logic [bba_pkg::WORD_W-1:0] r_mem [bba_pkg::MEM_DEPTH];
    logic [bba_pkg::WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/bba_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_search
// Two-level full-word summary: finds the lowest word of the map that still
// has a clear bit, and tracks full words as the map is written back.
// ----------------------------------------------------------------------------
module bba_search (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bba_pkg::t_sum_upd             i_upd,
    output logic                          o_any_free,
    output logic [bba_pkg::ADDR_W-1:0]    o_free_addr
);

    logic [bba_pkg::WORD_W-1:0]     r_summary    [bba_pkg::NUM_GROUPS];
    logic [bba_pkg::NUM_GROUPS-1:0] r_group_full;

    logic [bba_pkg::GRP_W-1:0]  w_grp;
    logic                       w_grp_hit;
    logic [bba_pkg::SEL_W:0]    w_sel;
    logic [bba_pkg::GRP_W-1:0]  w_upd_grp;
    logic [bba_pkg::SEL_W-1:0]  w_upd_sel;
    logic [bba_pkg::WORD_W-1:0] w_upd_word;

    // Lowest group that is not full.
    always_comb begin
        w_grp     = '0;
        w_grp_hit = 1'b0;
        for (int g = bba_pkg::NUM_GROUPS - 1; g >= 0; g--) begin
            if (!r_group_full[g]) begin
                w_grp     = bba_pkg::GRP_W'(g);
                w_grp_hit = 1'b1;
            end
        end
    end

    assign w_sel       = bba_pkg::first_zero(r_summary[w_grp]);
    assign o_any_free  = w_grp_hit;
    assign o_free_addr = {w_grp, w_sel[bba_pkg::SEL_W-1:0]};

    assign w_upd_grp = i_upd.addr[bba_pkg::ADDR_W-1:bba_pkg::SEL_W];
    assign w_upd_sel = i_upd.addr[bba_pkg::SEL_W-1:0];

    always_comb begin
        w_upd_word            = r_summary[w_upd_grp];
        w_upd_word[w_upd_sel] = i_upd.full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < bba_pkg::NUM_GROUPS; g++) begin
                r_summary[g] <= bba_pkg::summary_init(g);
            end
            r_group_full <= '0;
        end else if (i_upd.en) begin
            r_summary[w_upd_grp]    <= w_upd_word;
            r_group_full[w_upd_grp] <= &w_upd_word;
        end
    end

endmodule
